// ===== rtl/a2a_pkg.sv =====
// shared types and constants for the avcc to annex b converter
package a2a_pkg;

    localparam int TOTAL_BITS = 17;
    localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = 17'h1ffff;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_TRUNC = 2'd1;
    localparam logic [1:0] ST_SHORT = 2'd2;

    localparam logic [7:0] SC_ZERO = 8'h00;
    localparam logic [7:0] SC_LAST = 8'h01;
    localparam logic [2:0] SC_BYTES = 3'd4;

    localparam logic [7:0] SPS_COUNT_MASK = 8'h1f;
    localparam logic [7:0] LSZ_MASK = 8'h03;

    localparam int CMDQ_DEPTH = 2;

    typedef struct packed {
        logic [7:0]            data;
        logic                  emit_byte;
        logic                  emit_sc;
        logic                  fin;
        logic [1:0]            status;
        logic [2:0]            nal_size;
        logic [TOTAL_BITS-1:0] base_total;
    } cmd_t;

endpackage

// ===== rtl/a2a_front.sv =====
// front end: parses record bytes and issues output commands
module a2a_front #(
    parameter int RECORD_LEN_BITS = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [RECORD_LEN_BITS-1:0] record_length,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [7:0]                 in_byte,
    input  logic                       cmd_full,
    output logic                       cmd_push,
    output a2a_pkg::cmd_t              cmd
);
    import a2a_pkg::*;

    localparam int LW = RECORD_LEN_BITS;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_COUNT,
        PH_LEN_HI,
        PH_LEN_LO,
        PH_PAYLOAD,
        PH_DRAIN
    } phase_t;

    phase_t                phase_reg, phase_next;
    logic [LW-1:0]         idx_reg, idx_next;
    logic [7:0]            units_reg, units_next;
    logic                  pps_reg, pps_next;
    logic [7:0]            ulen_hi_reg, ulen_hi_next;
    logic [15:0]           pay_reg, pay_next;
    logic [2:0]            lsz_reg, lsz_next;
    logic [TOTAL_BITS-1:0] total_reg, total_next;
    logic                  fin_reg, fin_next;

    logic                  accept;
    logic [LW:0]           idx_inc;
    logic                  past_end;
    logic                  at_last;
    logic [17:0]           reach;
    logic [15:0]           ulen;
    logic [15:0]           pay_dec;
    logic [7:0]            count;
    logic                  unit_end;
    logic                  set_empty;
    logic                  do_fin;
    logic [1:0]            fin_status;
    logic                  emit_byte;
    logic                  emit_sc;
    logic                  do_clear;
    logic [2:0]            add_cnt;
    logic [TOTAL_BITS:0]   total_sum;
    logic [7:0]            units_dec;
    logic [2:0]            lsz_emit;

    assign in_ready = !cmd_full;
    assign accept   = in_valid && in_ready;
    assign idx_inc  = {1'b0, idx_reg} + {{LW{1'b0}}, 1'b1};
    assign past_end = (idx_reg >= record_length);
    assign at_last  = (idx_inc == {1'b0, record_length});
    assign ulen     = {ulen_hi_reg, in_byte};
    assign reach    = {{(18-LW-1){1'b0}}, idx_inc} + {2'b00, ulen};
    assign pay_dec  = pay_reg - 16'd1;
    assign units_dec = units_reg - 8'd1;
    assign count    = pps_reg ? in_byte : (in_byte & SPS_COUNT_MASK);

    always_comb
    begin
        phase_next   = phase_reg;
        idx_next     = idx_reg;
        units_next   = units_reg;
        pps_next     = pps_reg;
        ulen_hi_next = ulen_hi_reg;
        pay_next     = pay_reg;
        lsz_next     = lsz_reg;
        fin_next     = fin_reg;
        unit_end     = 1'b0;
        set_empty    = 1'b0;
        do_fin       = 1'b0;
        fin_status   = ST_OK;
        emit_byte    = 1'b0;
        emit_sc      = 1'b0;
        do_clear     = 1'b0;

        if (past_end)
        begin
            if (!fin_reg)
            begin
                do_fin     = 1'b1;
                fin_status = (phase_reg == PH_HEADER || phase_reg == PH_COUNT)
                             ? ST_SHORT : ST_TRUNC;
            end
            do_clear = 1'b1;
        end
        else
        begin
            if (!fin_reg)
            begin
                unique case (phase_reg)
                    PH_HEADER:
                    begin
                        if (idx_reg >= LW'(4))
                        begin
                            lsz_next   = 3'((in_byte & LSZ_MASK)) + 3'd1;
                            phase_next = PH_COUNT;
                        end
                    end
                    PH_COUNT:
                    begin
                        units_next = count;
                        if (count != 8'd0)
                            phase_next = PH_LEN_HI;
                        else
                            set_empty = 1'b1;
                    end
                    PH_LEN_HI:
                    begin
                        ulen_hi_next = in_byte;
                        phase_next   = PH_LEN_LO;
                    end
                    PH_LEN_LO:
                    begin
                        if (reach > {{(18-LW){1'b0}}, record_length})
                        begin
                            do_fin     = 1'b1;
                            fin_status = ST_TRUNC;
                        end
                        else
                        begin
                            emit_sc  = 1'b1;
                            pay_next = ulen;
                            if (ulen == 16'd0)
                                unit_end = 1'b1;
                            else
                                phase_next = PH_PAYLOAD;
                        end
                    end
                    PH_PAYLOAD:
                    begin
                        emit_byte = 1'b1;
                        pay_next  = pay_dec;
                        if (pay_dec == 16'd0)
                            unit_end = 1'b1;
                    end
                    default:
                    begin
                    end
                endcase

                if (unit_end)
                begin
                    units_next = units_dec;
                    if (units_dec != 8'd0)
                        phase_next = PH_LEN_HI;
                    else
                        set_empty = 1'b1;
                end

                if (set_empty)
                begin
                    if (!pps_reg)
                    begin
                        pps_next   = 1'b1;
                        phase_next = PH_COUNT;
                    end
                    else
                    begin
                        do_fin     = 1'b1;
                        fin_status = ST_OK;
                    end
                end

                if (do_fin)
                begin
                    fin_next   = 1'b1;
                    phase_next = PH_DRAIN;
                end
            end

            if (at_last)
            begin
                if (!fin_next)
                begin
                    do_fin     = 1'b1;
                    fin_status = (phase_next == PH_HEADER || phase_next == PH_COUNT)
                                 ? ST_SHORT : ST_TRUNC;
                end
                do_clear = 1'b1;
            end
            else
            begin
                idx_next = idx_inc[LW-1:0];
            end
        end

        add_cnt   = emit_sc ? SC_BYTES : {2'b00, emit_byte};
        total_sum = {1'b0, total_reg} + {{(TOTAL_BITS-2){1'b0}}, add_cnt};
        total_next = (total_sum > {1'b0, TOTAL_MAX}) ? TOTAL_MAX
                                                     : total_sum[TOTAL_BITS-1:0];

        // length size seen by this byte's transfers, before any restart
        lsz_emit = lsz_next;

        if (do_clear)
        begin
            phase_next   = PH_HEADER;
            idx_next     = '0;
            units_next   = 8'd0;
            pps_next     = 1'b0;
            ulen_hi_next = 8'd0;
            pay_next     = 16'd0;
            lsz_next     = 3'd1;
            total_next   = '0;
            fin_next     = 1'b0;
        end
    end

    assign cmd_push = accept && (emit_byte || emit_sc || do_fin);

    always_comb
    begin
        cmd.data       = in_byte;
        cmd.emit_byte  = emit_byte;
        cmd.emit_sc    = emit_sc;
        cmd.fin        = do_fin;
        cmd.status     = fin_status;
        cmd.nal_size   = lsz_emit;
        cmd.base_total = total_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_HEADER;
            idx_reg     <= '0;
            units_reg   <= 8'd0;
            pps_reg     <= 1'b0;
            ulen_hi_reg <= 8'd0;
            pay_reg     <= 16'd0;
            lsz_reg     <= 3'd1;
            total_reg   <= '0;
            fin_reg     <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg   <= phase_next;
            idx_reg     <= idx_next;
            units_reg   <= units_next;
            pps_reg     <= pps_next;
            ulen_hi_reg <= ulen_hi_next;
            pay_reg     <= pay_next;
            lsz_reg     <= lsz_next;
            total_reg   <= total_next;
            fin_reg     <= fin_next;
        end
    end

endmodule

// ===== rtl/a2a_cmd_fifo.sv =====
// short command queue between parser and output sequencer
module a2a_cmd_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  a2a_pkg::cmd_t push_cmd,
    input  logic          pop,
    output a2a_pkg::cmd_t head,
    output logic          empty,
    output logic          full
);
    import a2a_pkg::*;

    localparam int PW = $clog2(CMDQ_DEPTH);

    cmd_t          mem_reg [CMDQ_DEPTH];
    logic [PW-1:0] wptr_reg, rptr_reg;
    logic [PW:0]   cnt_reg;
    logic          do_push;
    logic          do_pop;

    assign empty   = (cnt_reg == '0);
    assign full    = (cnt_reg == (PW+1)'(CMDQ_DEPTH));
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem_reg[rptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wptr_reg <= (wptr_reg == PW'(CMDQ_DEPTH-1)) ? '0 : wptr_reg + PW'(1);
            if (do_pop)
                rptr_reg <= (rptr_reg == PW'(CMDQ_DEPTH-1)) ? '0 : rptr_reg + PW'(1);
            if (do_push && !do_pop)
                cnt_reg <= cnt_reg + (PW+1)'(1);
            else if (do_pop && !do_push)
                cnt_reg <= cnt_reg - (PW+1)'(1);
        end
    end

endmodule

// ===== rtl/a2a_back.sv =====
// back end: expands commands into registered output transfers
module a2a_back (
    input  logic          clk,
    input  logic          rst_n,
    input  a2a_pkg::cmd_t head,
    input  logic          empty,
    output logic          pop,
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [31:0]   m_tdata,
    output logic          m_tuser,
    output logic          m_tlast
);
    import a2a_pkg::*;

    logic [2:0]            seq_reg;
    logic                  valid_reg;
    logic [7:0]            byte_reg;
    logic                  bvalid_reg;
    logic                  done_reg;
    logic [1:0]            status_reg;
    logic [2:0]            nal_reg;
    logic [TOTAL_BITS-1:0] total_reg;

    logic                  load;
    logic [2:0]            nbytes;
    logic [2:0]            nsteps;
    logic                  last_step;
    logic                  is_byte;
    logic [2:0]            offset;
    logic [TOTAL_BITS:0]   total_sum;
    logic [TOTAL_BITS-1:0] total_sat;
    logic [7:0]            byte_val;

    assign load      = (!valid_reg || m_tready) && !empty;
    assign nbytes    = head.emit_sc ? SC_BYTES : {2'b00, head.emit_byte};
    assign nsteps    = nbytes + {2'b00, head.fin};
    assign last_step = (seq_reg + 3'd1 == nsteps);
    assign pop       = load && last_step;
    assign is_byte   = (seq_reg < nbytes);
    assign offset    = is_byte ? seq_reg + 3'd1 : nbytes;
    assign total_sum = {1'b0, head.base_total} + {{(TOTAL_BITS-2){1'b0}}, offset};
    assign total_sat = (total_sum > {1'b0, TOTAL_MAX}) ? TOTAL_MAX
                                                       : total_sum[TOTAL_BITS-1:0];

    always_comb
    begin
        if (!is_byte)
            byte_val = 8'h00;
        else if (head.emit_byte)
            byte_val = head.data;
        else if (seq_reg == SC_BYTES - 3'd1)
            byte_val = SC_LAST;
        else
            byte_val = SC_ZERO;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg   <= byte_val;
            bvalid_reg <= is_byte;
            done_reg   <= !is_byte;
            status_reg <= is_byte ? ST_OK : head.status;
            nal_reg    <= head.nal_size;
            total_reg  <= total_sat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            seq_reg   <= 3'd0;
        end
        else
        begin
            if (load)
            begin
                valid_reg <= 1'b1;
                seq_reg   <= last_step ? 3'd0 : seq_reg + 3'd1;
            end
            else if (m_tready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tuser  = bvalid_reg;
    assign m_tlast  = done_reg;
    assign m_tdata  = {2'b00, total_reg, nal_reg, status_reg, byte_reg};

endmodule

// ===== rtl/avcc_to_annexb_converter_top.sv =====
// top level of the avcc to annex b converter
//
// record bytes enter on the s_ channel, one per transfer; results leave on the
// m_ channel. cfg_data sets the record length; the user must see it written
// only while idle, the block does not enforce this. the parser handles one
// byte per cycle while the queue is not full and pushes at most one command
// per byte into a two-entry queue; the output sequencer turns each command
// into one to five transfers (payload byte, four start code bytes, final
// status). a byte's command is registered in the queue, then in the output
// register. payload bytes stream at one per cycle while m_tready is high;
// each unit's start code takes four output transfers, so input stalls once
// the queue fills. the final transfer of a record has tlast high and tuser
// low and carries the status and total output size. when the receiver holds
// m_tready low the output register keeps its transfer, the queue fills and
// s_tready drops once it holds two commands. reset clears the parser to the
// header phase, empties the queue and sets the record length to zero.
module avcc_to_annexb_converter_top #(
    parameter int RECORD_LEN_BITS = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [RECORD_LEN_BITS-1:0] cfg_data,   // record_length
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [7:0]                 s_tdata,    // in_byte
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // out_byte[7:0], status[9:8], nal_length_size[12:10], total_out[29:13]
    output logic [31:0]                m_tdata,
    output logic                       m_tuser,    // byte_valid
    output logic                       m_tlast     // done_res
);
    import a2a_pkg::*;

    logic [RECORD_LEN_BITS-1:0] record_length_reg;
    logic                       cmd_push;
    cmd_t                       cmd;
    cmd_t                       head;
    logic                       q_empty;
    logic                       q_full;
    logic                       q_pop;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            record_length_reg <= '0;
        else if (cfg_valid)
            record_length_reg <= cfg_data;
    end

    a2a_front #(
        .RECORD_LEN_BITS(RECORD_LEN_BITS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .record_length(record_length_reg),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .in_byte      (s_tdata),
        .cmd_full     (q_full),
        .cmd_push     (cmd_push),
        .cmd          (cmd)
    );

    a2a_cmd_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (cmd_push),
        .push_cmd(cmd),
        .pop     (q_pop),
        .head    (head),
        .empty   (q_empty),
        .full    (q_full)
    );

    a2a_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .head    (head),
        .empty   (q_empty),
        .pop     (q_pop),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

endmodule

// ===== rtl/a2a_checker.sv =====
// port level checks for the converter top, attached by bind
module a2a_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        m_tuser,
    input logic        m_tlast
);

    // stalled output transfer holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)
                                  && $stable(m_tuser) && $stable(m_tlast))
        else $error("output changed while stalled");

    // stream bytes never end the record and carry ok status
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> !m_tlast && m_tdata[9:8] == 2'd0)
        else $error("stream byte with done or status");

    // status-only transfers end the record with zero byte and a legal status
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tlast && m_tdata[7:0] == 8'h00
                                 && m_tdata[9:8] != 2'd3)
        else $error("bad status-only transfer");

    // consecutive byte transfers of one record count up by one
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && m_tuser && m_tdata[29:13] != 17'h1ffff
        ##1 m_tvalid && m_tuser && m_tdata[29:13] != 17'd1
        |-> m_tdata[29:13] == $past(m_tdata[29:13]) + 17'd1)
        else $error("total count skipped");

endmodule

bind avcc_to_annexb_converter_top a2a_checker u_a2a_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .m_tlast (m_tlast)
);
